FILE: rtl/spherical_uv_generator_top_defines.svh
// Assertion macros for the spherical UV generator checker.
// No dependencies; included by the checker file.
`ifndef SPHERICAL_UV_GENERATOR_TOP_DEFINES_SVH
`define SPHERICAL_UV_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk
`define SUVG_ASSERT_IMPL(lbl, dis, a, c) \
  lbl: assert property (@(posedge clk) disable iff (dis) (a) |-> (c)) \
    else $error("suvg check failed");

// next-cycle implication, sampled on clk
`define SUVG_ASSERT_NEXT(lbl, dis, a, c) \
  lbl: assert property (@(posedge clk) disable iff (dis) (a) |=> (c)) \
    else $error("suvg check failed");

`endif

FILE: rtl/suvg_pkg.sv
// Shared types, widths and the arctangent table of the spherical UV generator.
// No dependencies.
package suvg_pkg;

  localparam int COORD_BITS   = 16;
  localparam int UV_FRAC_BITS = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int NORM_MSB     = 30;   // normalize until |max| >= 2^30
  localparam int XW  = 35;            // CORDIC x/y width
  localparam int AW  = 34;            // angle accumulator, 2^-32 turns
  localparam int SW  = 2 * COORD_BITS + 2;             // |p|^2
  localparam int TW  = 2 * COORD_BITS + 2 * UV_FRAC_BITS; // y^2 * 2^2F
  localparam int PW  = TW + 6;        // search partial products
  localparam int SHW = 5;             // shift / step index width

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic                         is_last;
  } vtx_t;

  typedef struct packed {
    logic [UV_FRAC_BITS-1:0] tex_u;
    logic [UV_FRAC_BITS-1:0] tex_v;
    logic                    last_out;
  } uv_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] acc;
  } cordic_t;

  typedef struct packed {
    logic        [SW-1:0]           s;
    logic        [TW-1:0]           t;
    logic signed [PW-1:0]           p;
    logic signed [PW-1:0]           e;
    logic        [UV_FRAC_BITS-1:0] j;
    logic                           neg;
  } srch_t;

  function automatic logic signed [AW-1:0] atan_turns(input logic [SHW-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return signed'(AW'(r));
  endfunction

endpackage

FILE: rtl/suvg_cordic_step.sv
// One registered CORDIC vectoring step for the u angle.
// Uses suvg_pkg.
module suvg_cordic_step import suvg_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic           active,
  input  logic [SHW-1:0] step,
  input  cordic_t        d,
  output cordic_t        q
);

  cordic_t q_next;

  always_comb begin
    q_next = d;
    if (active) begin
      if (d.y >= 0) begin
        q_next.x   = d.x + (d.y >>> step);
        q_next.y   = d.y - (d.x >>> step);
        q_next.acc = d.acc + atan_turns(step);
      end else begin
        q_next.x   = d.x - (d.y >>> step);
        q_next.y   = d.y + (d.x >>> step);
        q_next.acc = d.acc - atan_turns(step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end

endmodule

FILE: rtl/suvg_vsrch_step.sv
// One registered bit of the exact search for v: decides one bit of j with
// incremental squares (no square root). Uses suvg_pkg.
module suvg_vsrch_step import suvg_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic           active,
  input  logic [SHW-1:0] bit_idx,
  input  srch_t          d,
  output srch_t          q
);

  srch_t                q_next;
  logic signed [PW-1:0] s_w;
  logic signed [PW-1:0] t_w;
  logic signed [PW-1:0] trial;
  logic                 ok;

  always_comb begin
    s_w   = signed'(PW'(d.s));
    t_w   = signed'(PW'(d.t));
    // (e + 2^(b+1))^2 * s from e^2*s and e*s
    trial = d.p + (d.e <<< (bit_idx + 2)) + (s_w <<< (2 * bit_idx + 2));
    ok    = d.neg ? (trial < t_w) : (trial <= t_w);
    q_next = d;
    if (active && ok) begin
      q_next.j = d.j | (UV_FRAC_BITS'(1) << bit_idx);
      q_next.p = trial;
      q_next.e = d.e + (s_w <<< (bit_idx + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end

endmodule

FILE: rtl/spherical_uv_generator_top.sv
// Spherical UV generator: one vertex position in, one (u, v) texture coordinate out.
// Input reg, pre and setup stages, step stages and output reg share one advance enable.
// Throughput: one item per cycle while the output is not held; the 30-step CORDIC
// chain and the 16-step v search run side by side, one step per register stage.
// Reset (rst, synchronous, active high) clears the valid bits only; data regs are free.
// Uses suvg_pkg, suvg_cordic_step and suvg_vsrch_step.
module spherical_uv_generator_top import suvg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic vtx_valid,
  output logic vtx_ready,
  input  vtx_t vtx,
  output logic uv_valid,
  input  logic uv_ready,
  output uv_t  uv
);

  localparam int NS = CORDIC_STEPS;
  localparam int CB = COORD_BITS;
  localparam int F  = UV_FRAC_BITS;
  localparam logic [F-1:0] HALF = F'(1) << (F - 1);
  localparam logic [F-1:0] TOP  = '1;

  // per-item flags that ride along the whole pipe
  typedef struct packed {
    logic zero;   // all coordinates zero
    logic pole;   // x = z = 0
    logic last;
  } meta_t;

  // first compute stage: squares and normalizing shift
  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] z;
    logic                 yneg;
    logic [2*CB-1:0]      xx;
    logic [2*CB-1:0]      yy;
    logic [2*CB-1:0]      zz;
    logic [SHW-1:0]       sh;
    meta_t                meta;
  } pre_t;

  // the whole pipe moves when the output slot is free or being emptied
  logic en;
  assign en        = !uv_valid || uv_ready;
  assign vtx_ready = en;

  // valid bits: input reg, pre stage, setup stage, NS step stages
  logic [NS+2:0] vld;

  vtx_t  r0;
  pre_t  r1;
  pre_t  r1_next;
  meta_t meta_st [NS+1];
  cordic_t cst   [NS+1];
  srch_t   sst   [NS+1];
  cordic_t c_init;
  srch_t   s_init;
  uv_t     uv_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      uv_valid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[NS+1:0], vtx_valid};
      uv_valid <= vld[NS+2];
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (en) r0 <= vtx;
  end

  // stage 1: abs, max, leading-one search, squares
  always_comb begin
    logic signed [CB:0] xe;
    logic signed [CB:0] ze;
    logic [CB:0]        ax;
    logic [CB:0]        az;
    logic [CB:0]        m;
    logic [SHW-1:0]     msb;
    logic signed [2*CB-1:0] px;
    logic signed [2*CB-1:0] py;
    logic signed [2*CB-1:0] pz;
    xe  = (CB+1)'(r0.pos_x);
    ze  = (CB+1)'(r0.pos_z);
    ax  = (xe < 0) ? unsigned'(-xe) : unsigned'(xe);
    az  = (ze < 0) ? unsigned'(-ze) : unsigned'(ze);
    m   = (ax > az) ? ax : az;
    msb = '0;
    for (int b = 0; b <= CB; b++) begin
      if (m[b]) msb = SHW'(b);
    end
    px = r0.pos_x * r0.pos_x;
    py = r0.pos_y * r0.pos_y;
    pz = r0.pos_z * r0.pos_z;
    r1_next.x    = r0.pos_x;
    r1_next.z    = r0.pos_z;
    r1_next.yneg = r0.pos_y[CB-1];
    r1_next.xx   = unsigned'(px);
    r1_next.yy   = unsigned'(py);
    r1_next.zz   = unsigned'(pz);
    r1_next.sh   = (int'(msb) >= NORM_MSB) ? '0 : SHW'(NORM_MSB - int'(msb));
    r1_next.meta.pole = (r0.pos_x == '0) && (r0.pos_z == '0);
    r1_next.meta.zero = r1_next.meta.pole && (r0.pos_y == '0);
    r1_next.meta.last = r0.is_last;
  end

  always_ff @(posedge clk) begin
    if (en) r1 <= r1_next;
  end

  // stage 2: |p|^2, scaled vector turned into the right half plane, search init
  always_comb begin
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] zs;
    xs = XW'(r1.x) <<< r1.sh;
    zs = XW'(r1.z) <<< r1.sh;
    c_init.x   = zs;
    c_init.y   = xs;
    c_init.acc = '0;
    if (zs < 0) begin
      if (xs >= 0) begin
        c_init.x   = xs;
        c_init.y   = -zs;
        c_init.acc = AW'(1) <<< 30;
      end else begin
        c_init.x   = -xs;
        c_init.y   = zs;
        c_init.acc = -(AW'(1) <<< 30);
      end
    end
    s_init.s   = SW'(r1.xx) + SW'(r1.yy) + SW'(r1.zz);
    s_init.t   = TW'(r1.yy) << (2 * F);
    // start from e = -1: e^2*s = s, e*s = -s
    s_init.p   = signed'(PW'(s_init.s));
    s_init.e   = -signed'(PW'(s_init.s));
    s_init.j   = '0;
    s_init.neg = r1.yneg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cst[0]     <= c_init;
      sst[0]     <= s_init;
      meta_st[0] <= r1.meta;
    end
  end

  // step stages: CORDIC step i and, for the first F stages, one bit of j (MSB first)
  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam int B = (i < F) ? (F - 1 - i) : 0;

    suvg_cordic_step u_cordic (
      .clk    (clk),
      .en     (en),
      .active (1'b1),
      .step   (SHW'(i)),
      .d      (cst[i]),
      .q      (cst[i+1])
    );

    suvg_vsrch_step u_vsrch (
      .clk     (clk),
      .en      (en),
      .active  ((i < F) ? 1'b1 : 1'b0),
      .bit_idx (SHW'(B)),
      .d       (sst[i]),
      .q       (sst[i+1])
    );

    always_ff @(posedge clk) begin
      if (en) meta_st[i+1] <= meta_st[i];
    end
  end

  // output stage: round u to F bits, map j onto v, clamp, special cases
  always_comb begin
    logic signed [AW-1:0] t;
    logic signed [AW-1:0] qu;
    logic [F:0]           k;
    t  = cst[NS].acc + (AW'(1) <<< 31) + (AW'(1) <<< (31 - F));
    qu = t >>> (32 - F);
    if (t < 0) begin
      uv_next.tex_u = '0;
    end else if (qu > signed'(AW'(TOP))) begin
      uv_next.tex_u = TOP;
    end else begin
      uv_next.tex_u = qu[F-1:0];
    end
    if (sst[NS].neg) begin
      k = (F+1)'(HALF) - (F+1)'(sst[NS].j);
    end else begin
      k = (F+1)'(HALF) + (F+1)'(sst[NS].j);
    end
    uv_next.tex_v = k[F] ? TOP : k[F-1:0];
    if (meta_st[NS].pole) uv_next.tex_u = HALF;
    if (meta_st[NS].zero) uv_next.tex_v = HALF;
    uv_next.last_out = meta_st[NS].last;
  end

  always_ff @(posedge clk) begin
    if (en) uv <= uv_next;
  end

endmodule

FILE: rtl/suvg_checker.sv
// Port-level checker for spherical_uv_generator_top, bound to the top level.
// Uses suvg_pkg and spherical_uv_generator_top_defines.svh.
`include "spherical_uv_generator_top_defines.svh"

module suvg_checker import suvg_pkg::*; (
  input logic clk,
  input logic rst,
  input logic vtx_valid,
  input logic vtx_ready,
  input vtx_t vtx,
  input logic uv_valid,
  input logic uv_ready,
  input uv_t  uv
);

  `SUVG_ASSERT_NEXT(a_reset_empty, 1'b0, rst, !uv_valid)
  `SUVG_ASSERT_NEXT(a_in_hold, rst, vtx_valid && !vtx_ready, vtx_valid && $stable(vtx))
  `SUVG_ASSERT_NEXT(a_out_hold, rst, uv_valid && !uv_ready, uv_valid && $stable(uv))
  `SUVG_ASSERT_IMPL(a_stall_back, rst, uv_valid && !uv_ready, !vtx_ready)
  `SUVG_ASSERT_IMPL(a_free_ready, rst, !uv_valid, vtx_ready)

endmodule

bind spherical_uv_generator_top suvg_checker u_suvg_checker (.*);

FILE: tb/spherical_uv_generator_top_tb.sv
// Testbench for spherical_uv_generator_top: a directed table of vertices, then random ones.
// A bit-exact predictor (CORDIC for u, exact square search for v) checks every result.
// Depends on suvg_pkg and the RTL of spherical_uv_generator_top.
`timescale 1ns / 1ps

module spherical_uv_generator_top_tb;
  import suvg_pkg::*;

  localparam int F = UV_FRAC_BITS;
  localparam int N_RANDOM = 400;
  localparam int CALM_TAIL = 80;      // last random items: no idling on either side
  localparam int LATENCY = 33;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vtx_valid = 1'b0;
  logic vtx_ready;
  vtx_t vtx = '0;
  logic uv_valid;
  logic uv_ready = 1'b0;
  uv_t  uv;

  spherical_uv_generator_top dut (
    .clk(clk), .rst(rst),
    .vtx_valid(vtx_valid), .vtx_ready(vtx_ready), .vtx(vtx),
    .uv_valid(uv_valid), .uv_ready(uv_ready), .uv(uv)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  localparam longint ATAN_TBL [CORDIC_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };

  // u: atan2(x, z) in 2^-32 turns via normalized CORDIC vectoring, then rounded to 0.F
  function automatic logic [F-1:0] angle_to_u(input longint x, input longint z);
    longint ax, az, m, cx, cy, acc, dx, dy, t, q, ox;
    ax = (x < 0) ? -x : x;
    az = (z < 0) ? -z : z;
    m = (ax > az) ? ax : az;
    cx = z;
    cy = x;
    acc = 0;
    while (m < (64'sd1 <<< 30)) begin
      m = m * 2;
      cx = cx * 2;
      cy = cy * 2;
    end
    // fold into the right half plane first
    if (cx < 0) begin
      ox = cx;
      if (cy >= 0) begin
        cx = cy; cy = -ox; acc = 64'sd1 <<< 30;
      end else begin
        cx = -cy; cy = ox; acc = -(64'sd1 <<< 30);
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; acc += ATAN_TBL[i];
      end else begin
        cx -= dx; cy += dy; acc -= ATAN_TBL[i];
      end
    end
    t = acc + (64'sd1 <<< 31) + (64'sd1 <<< (31 - F));
    if (t < 0) return '0;
    q = t >>> (32 - F);
    if (q > (64'sd1 <<< F) - 1) return '1;
    return q[F-1:0];
  endfunction

  // k is acceptable when (2k - 1 - 2^F) * |p| <= y * 2^F, decided on squares
  function automatic bit v_step_ok(input longint k, input longint y, input logic [127:0] s);
    longint d;
    logic [127:0] ad, lhs, rhs;
    d = 2 * k - 1 - (64'sd1 <<< F);
    ad = (d < 0) ? 128'(-d) : 128'(d);
    lhs = ad * ad * s;
    rhs = (128'(y * y)) << (2 * F);
    if (d <= 0 && y >= 0) return 1'b1;
    if (d > 0 && y < 0) return 1'b0;
    if (d > 0) return lhs <= rhs;
    return lhs >= rhs;
  endfunction

  function automatic uv_t predict_uv(input vtx_t p);
    uv_t r;
    longint x, y, z, lo, hi, mid;
    logic [127:0] s;
    x = longint'(p.pos_x);
    y = longint'(p.pos_y);
    z = longint'(p.pos_z);
    s = 128'(x * x + y * y + z * z);
    r.last_out = p.is_last;
    if (s == 0) begin
      r.tex_u = F'(1 << (F - 1));
      r.tex_v = F'(1 << (F - 1));
      return r;
    end
    lo = 0;
    hi = (64'sd1 <<< F) + 1;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (v_step_ok(mid, y, s)) lo = mid;
      else hi = mid;
    end
    r.tex_v = (lo > (64'sd1 <<< F) - 1) ? '1 : lo[F-1:0];
    // pole: atan2(0, 0) is taken as zero
    r.tex_u = (x == 0 && z == 0) ? F'(1 << (F - 1)) : angle_to_u(x, z);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table; known results typed in where obvious
  // ---------------------------------------------------------------------------
  typedef struct {
    vtx_t in;
    bit   known;
    uv_t  res;
  } vec_row_t;

  localparam logic [F-1:0] HALF = 16'h8000;
  localparam logic [F-1:0] TOP  = 16'hFFFF;

  vec_row_t vec_table [] = '{
    '{ '{16'sd0, 16'sd0, 16'sd0, 1'b0}, 1, '{HALF, HALF, 1'b0} },          // zero vector
    '{ '{16'sd0, 16'sd0, 16'sd0, 1'b1}, 1, '{HALF, HALF, 1'b1} },
    '{ '{16'sd0, 16'sd1000, 16'sd0, 1'b0}, 1, '{HALF, TOP, 1'b0} },        // +y pole
    '{ '{16'sd0, 16'sd32767, 16'sd0, 1'b1}, 1, '{HALF, TOP, 1'b1} },
    '{ '{16'sd0, -16'sd32768, 16'sd0, 1'b0}, 1, '{HALF, 16'h0000, 1'b0} }, // -y pole
    '{ '{16'sd0, -16'sd1, 16'sd0, 1'b0}, 1, '{HALF, 16'h0000, 1'b0} },
    '{ '{16'sd0, 16'sd0, 16'sd5, 1'b0}, 1, '{HALF, HALF, 1'b0} },          // +z
    '{ '{16'sd0, 16'sd0, -16'sd5, 1'b0}, 1, '{TOP, HALF, 1'b0} },          // -z: u hits 1.0
    '{ '{16'sd0, 16'sd0, -16'sd32768, 1'b1}, 1, '{TOP, HALF, 1'b1} },
    '{ '{16'sd32767, 16'sd0, 16'sd0, 1'b0}, 0, '0 },
    '{ '{-16'sd32768, 16'sd0, 16'sd0, 1'b0}, 0, '0 },
    '{ '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0}, 0, '0 },
    '{ '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1}, 0, '0 },
    '{ '{16'sd1, 16'sd1, 16'sd1, 1'b0}, 0, '0 },
    '{ '{-16'sd1, -16'sd1, -16'sd1, 1'b0}, 0, '0 },
    '{ '{16'sd1, 16'sd0, -16'sd1, 1'b0}, 0, '0 },
    '{ '{-16'sd1, 16'sd0, -16'sd1, 1'b0}, 0, '0 },
    '{ '{-16'sd32768, 16'sd1, -16'sd32768, 1'b0}, 0, '0 },
    '{ '{16'sd3, 16'sd4, 16'sd0, 1'b0}, 0, '0 },
    '{ '{16'sd32767, -16'sd32768, 16'sd1, 1'b1}, 0, '0 }
  };

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------
  uv_t uv_expected [$];
  int  n_fail = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  idle_cycles = 0;
  bit  timed_out = 0;

  always @(posedge clk) begin
    uv_t want;
    if (!rst) begin
      if (vtx_valid && vtx_ready) uv_expected.push_back(predict_uv(vtx));
      if (uv_valid && uv_ready) begin
        n_checked++;
        if (uv_expected.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected uv item u=%h v=%h last=%b", $time,
                   uv.tex_u, uv.tex_v, uv.last_out);
        end else begin
          want = uv_expected.pop_front();
          if (uv.tex_u !== want.tex_u) begin
            n_fail++;
            $display("%0t: tex_u expected %h actual %h", $time, want.tex_u, uv.tex_u);
          end
          if (uv.tex_v !== want.tex_v) begin
            n_fail++;
            $display("%0t: tex_v expected %h actual %h", $time, want.tex_v, uv.tex_v);
          end
          if (uv.last_out !== want.last_out) begin
            n_fail++;
            $display("%0t: last_out expected %b actual %b", $time,
                     want.last_out, uv.last_out);
          end
        end
      end
      // watchdog on lack of progress
      if ((vtx_valid && vtx_ready) || (uv_valid && uv_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // typed-in results from the table are checked against the predictor too,
  // so a predictor slip shows up as well as an RTL one
  initial begin
    uv_t got;
    foreach (vec_table[i]) begin
      if (vec_table[i].known) begin
        got = predict_uv(vec_table[i].in);
        if (got !== vec_table[i].res) begin
          n_fail++;
          $display("%0t: directed row %0d expected %h actual %h", $time, i,
                   vec_table[i].res, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off, none at the tail
  // ---------------------------------------------------------------------------
  bit hold_req = 0;
  bit calm = 0;

  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        uv_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        uv_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = calm ? 1 : $urandom_range(1, 20);
        uv_ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // hold the item until accepted; ready is looked at mid-cycle where it is settled
  task automatic offer_vertex(input vtx_t p);
    bit taken;
    vtx <= p;
    vtx_valid <= 1'b1;
    n_sent++;
    do begin
      @(negedge clk);
      taken = vtx_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic maybe_gap();
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 12);
      vtx_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_coord(input int mag);
    logic signed [15:0] c;
    case (mag)
      0: c = 16'($signed($urandom_range(0, 6)) - 3);
      1: c = 16'($signed($urandom_range(0, 512)) - 256);
      default: c = 16'($urandom);
    endcase
    return c;
  endfunction

  function automatic vtx_t random_vertex();
    vtx_t p;
    int shape;
    shape = $urandom_range(0, 9);
    p.pos_x = rand_coord($urandom_range(0, 2));
    p.pos_y = rand_coord($urandom_range(0, 2));
    p.pos_z = rand_coord($urandom_range(0, 2));
    p.is_last = 1'($urandom_range(0, 1));
    // axes and planes now and then: poles, seams and the half-plane fold
    if (shape == 0) p.pos_x = '0;
    if (shape == 1) p.pos_z = '0;
    if (shape == 2) begin
      p.pos_x = '0; p.pos_z = '0;
    end
    if (shape == 3) p.pos_y = '0;
    return p;
  endfunction

  initial begin
    vtx_t p;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vec_table[i]) begin
      offer_vertex(vec_table[i].in);
      maybe_gap();
    end

    // stall the output long enough that the pipeline backs up into vtx_ready
    hold_req = 1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        // sender goes quiet until the pipe has drained
        vtx_valid <= 1'b0;
        @(posedge clk);
        while (uv_expected.size() != 0) @(posedge clk);
      end
      if (i == N_RANDOM - CALM_TAIL) calm = 1;
      p = random_vertex();
      offer_vertex(p);
      maybe_gap();
    end
    vtx_valid <= 1'b0;

    while (uv_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Sent %0d vertices (%0d directed), checked %0d uv items, incl. poles,",
             n_sent, vec_table.size(), n_checked);
    $display("zero vectors, seams, full-scale extremes, long output stall and drain pause.");
    if (n_fail == 0 && uv_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!timed_out && idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1;
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/suvg_pkg.sv
rtl/suvg_cordic_step.sv
rtl/suvg_vsrch_step.sv
rtl/spherical_uv_generator_top.sv
rtl/suvg_checker.sv
tb/spherical_uv_generator_top_tb.sv
